### rtl/separable_pixel_blend_defines.svh
// ----------------------------------------------------------------------------
// Separable pixel blend assertion macros
// Shared property wrappers clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_PIXEL_BLEND_DEFINES_SVH
`define SEPARABLE_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication.
`define SBL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbl check failed");

// Next-cycle implication.
`define SBL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbl check failed");

`endif

### rtl/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared constants, types and the soft light square root table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbl_pkg;

    localparam int NUM_LANES = 3;
    localparam int DIV_STAGES = 4;
    localparam int NUM_STAGES = DIV_STAGES + 4;
    localparam int NUM_W = 35;
    localparam int DEN_W = 26;

    localparam logic [4:0] MODE_NORMAL     = 5'd0;
    localparam logic [4:0] MODE_MULTIPLY   = 5'd1;
    localparam logic [4:0] MODE_SCREEN     = 5'd2;
    localparam logic [4:0] MODE_OVERLAY    = 5'd3;
    localparam logic [4:0] MODE_DARKEN     = 5'd4;
    localparam logic [4:0] MODE_LIGHTEN    = 5'd5;
    localparam logic [4:0] MODE_DODGE      = 5'd6;
    localparam logic [4:0] MODE_BURN       = 5'd7;
    localparam logic [4:0] MODE_HARDLIGHT  = 5'd8;
    localparam logic [4:0] MODE_SOFTLIGHT  = 5'd9;
    localparam logic [4:0] MODE_DIFFERENCE = 5'd10;
    localparam logic [4:0] MODE_LINBURN    = 5'd11;
    localparam logic [4:0] MODE_PINLIGHT   = 5'd12;
    localparam logic [4:0] MODE_EXCLUSION  = 5'd13;
    localparam logic [4:0] MODE_LINDODGE   = 5'd14;
    localparam logic [4:0] MODE_SUBTRACT   = 5'd15;
    localparam logic [4:0] MODE_DIVIDE     = 5'd16;

    // Post-divide operation
    localparam logic [1:0] POST_QUOT   = 2'd0;
    localparam logic [1:0] POST_INV    = 2'd1;
    localparam logic [1:0] POST_EXCL   = 2'd2;
    localparam logic [1:0] POST_BYPASS = 2'd3;

    typedef struct packed {
        logic [1:0] post;
        logic [7:0] byp;
        logic [8:0] sum;
    } sbl_side_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } sbl_ctl_t;

    typedef logic [16:0] sqrt_tab_t [256];

    // Q1.16 entries: floor(65536*sqrt(d/255) + 1/2)
    function automatic sqrt_tab_t build_sqrt_tab();
        sqrt_tab_t   tab;
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bt;
        for (int d = 0; d < 256; d++)
        begin
            n = (64'(d) << 34) / 64'd255;
            root = 64'd0;
            bt = 64'd1 << 42;
            for (int i = 0; i < 22; i++)
            begin
                if (n >= root + bt)
                begin
                    n = n - (root + bt);
                    root = (root >> 1) + bt;
                end
                else
                begin
                    root = root >> 1;
                end
                bt = bt >> 2;
            end
            tab[d] = 17'((root + 64'd1) >> 1);
        end
        return tab;
    endfunction

    localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();

endpackage

### rtl/sbl_div.sv
// ----------------------------------------------------------------------------
// sbl_div
// Pipelined restoring divider, quotient saturated to 255, two bits a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbl_div
    import sbl_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] load,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    input  sbl_side_t             side_in,
    output logic [7:0]            quot,
    output sbl_side_t             side_out
);

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [7:0]       q_reg    [DIV_STAGES];
    logic             sat_reg  [DIV_STAGES];
    sbl_side_t        side_reg [DIV_STAGES];

    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [7:0]       q_next   [DIV_STAGES];
    logic             sat_next [DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_stage
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [7:0]       q_in;
            logic             sat_in;
            sbl_side_t        side_now;

            if (j == 0)
            begin : g_first
                assign rem_in   = num;
                assign den_in   = den;
                assign q_in     = 8'd0;
                assign sat_in   = (num >= (NUM_W'(den) << 8));
                assign side_now = side_in;
            end
            else
            begin : g_rest
                assign rem_in   = rem_reg[j-1];
                assign den_in   = den_reg[j-1];
                assign q_in     = q_reg[j-1];
                assign sat_in   = sat_reg[j-1];
                assign side_now = side_reg[j-1];
            end

            always_comb
            begin
                logic [NUM_W-1:0] r;
                logic [NUM_W-1:0] sh;
                logic [7:0]       q;
                r = rem_in;
                q = q_in;
                for (int b = 0; b < 2; b++)
                begin
                    sh = NUM_W'(den_in) << (7 - 2 * j - b);
                    if (r >= sh)
                    begin
                        r = r - sh;
                        q = q | (8'd1 << (7 - 2 * j - b));
                    end
                end
                rem_next[j] = r;
                q_next[j]   = q;
                sat_next[j] = sat_in;
            end

            always_ff @(posedge clk)
            begin
                if (load[j])
                begin
                    rem_reg[j]  <= rem_next[j];
                    den_reg[j]  <= den_in;
                    q_reg[j]    <= q_next[j];
                    sat_reg[j]  <= sat_next[j];
                    side_reg[j] <= side_now;
                end
            end
        end
    endgenerate

    assign quot     = sat_reg[DIV_STAGES-1] ? 8'd255 : q_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

### rtl/sbl_lane.sv
// ----------------------------------------------------------------------------
// sbl_lane
// One color channel: products, numerator/divisor select, divide, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbl_lane
    import sbl_pkg::*;
(
    input  logic       clk,
    input  sbl_ctl_t   ctl,
    input  logic [4:0] mode,
    input  logic [7:0] src,
    input  logic [7:0] dst,
    output logic [7:0] result
);

    // stage 0
    logic [7:0]         s0_reg, d0_reg, k0_reg;
    logic [15:0]        sd0_reg, ns0_reg;
    logic [13:0]        dm0_reg;
    logic signed [21:0] pq0_reg;
    logic [16:0]        t0_reg;
    // stage 1
    logic [7:0]         s1_reg, d1_reg, k1_reg;
    logic [15:0]        sd1_reg, ns1_reg;
    logic [21:0]        kdm1_reg;
    logic signed [33:0] pm1_reg;
    logic signed [26:0] sq1_reg;
    // stage 2
    logic [NUM_W-1:0]   num2_reg;
    logic [DEN_W-1:0]   den2_reg;
    sbl_side_t          side2_reg;
    // output
    logic [7:0]         res_reg;

    logic [7:0]         k0_next;
    logic signed [12:0] pqa;
    logic signed [33:0] pm1_next;
    logic signed [26:0] sq1_next;
    logic [NUM_W-1:0]   num2_next;
    logic [DEN_W-1:0]   den2_next;
    sbl_side_t          side2_next;
    logic [7:0]         quot;
    sbl_side_t          side_q;
    logic [7:0]         res_next;

    assign k0_next = src[7] ? {src[6:0], 1'b1} : ~{src[6:0], 1'b0};
    assign pqa     = $signed({1'b0, dst, 4'b0}) - 13'sd3060;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s0_reg  <= src;
            d0_reg  <= dst;
            k0_reg  <= k0_next;
            sd0_reg <= src * dst;
            ns0_reg <= (8'd255 - src) * (8'd255 - dst);
            dm0_reg <= 14'(16'(dst) * 16'(8'd255 - dst));
            pq0_reg <= pqa * $signed({1'b0, dst});
            t0_reg  <= SQRT_TAB[dst];
        end
    end

    // P - 65025d for dark destinations, 255T - 65536d otherwise
    assign pm1_next = 34'((34'(pq0_reg) + 34'sd260100) * $signed({26'b0, d0_reg}))
                      - $signed(34'(d0_reg) * 34'd65025);
    assign sq1_next = $signed(27'(t0_reg) * 27'd255) - $signed({3'b0, d0_reg, 16'b0});

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            s1_reg   <= s0_reg;
            d1_reg   <= d0_reg;
            k1_reg   <= k0_reg;
            sd1_reg  <= sd0_reg;
            ns1_reg  <= ns0_reg;
            kdm1_reg <= 22'(k0_reg) * 22'(dm0_reg);
            pm1_reg  <= pm1_next;
            sq1_reg  <= sq1_next;
        end
    end

    always_comb
    begin
        logic signed [33:0] sel;
        logic signed [42:0] kx;
        logic signed [42:0] num;
        logic [8:0]         sum;
        logic [7:0]         mn, mx, t;
        sel = (d1_reg < 8'd64) ? pm1_reg : 34'(sq1_reg);
        kx  = $signed({35'b0, k1_reg}) * 43'(sel);
        sum = 9'(s1_reg) + 9'(d1_reg);
        mn  = (s1_reg < d1_reg) ? s1_reg : d1_reg;
        mx  = (s1_reg > d1_reg) ? s1_reg : d1_reg;
        num = '0;
        t   = '0;
        num2_next       = '0;
        den2_next       = DEN_W'(255);
        side2_next.post = POST_QUOT;
        side2_next.byp  = s1_reg;
        side2_next.sum  = sum;
        case (mode)
            MODE_MULTIPLY:
            begin
                num2_next = NUM_W'(sd1_reg);
            end
            MODE_SCREEN:
            begin
                num2_next = NUM_W'(ns1_reg);
                side2_next.post = POST_INV;
            end
            MODE_OVERLAY, MODE_HARDLIGHT:
            begin
                if ((mode == MODE_OVERLAY) ? !d1_reg[7] : !s1_reg[7])
                begin
                    num2_next = NUM_W'(sd1_reg) << 1;
                end
                else
                begin
                    num2_next = NUM_W'(ns1_reg) << 1;
                    side2_next.post = POST_INV;
                end
            end
            MODE_DARKEN:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = mn;
            end
            MODE_LIGHTEN:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = mx;
            end
            MODE_DODGE:
            begin
                if (s1_reg == 8'd255)
                begin
                    side2_next.post = POST_BYPASS;
                    side2_next.byp  = 8'd255;
                end
                else
                begin
                    num2_next = NUM_W'(d1_reg) * NUM_W'(255);
                    den2_next = DEN_W'(8'd255 - s1_reg);
                end
            end
            MODE_BURN:
            begin
                if (s1_reg == 8'd0)
                begin
                    side2_next.post = POST_BYPASS;
                    side2_next.byp  = 8'd0;
                end
                else
                begin
                    num2_next = NUM_W'(8'd255 - d1_reg) * NUM_W'(255);
                    den2_next = DEN_W'(s1_reg);
                    side2_next.post = POST_INV;
                end
            end
            MODE_SOFTLIGHT:
            begin
                // numerator 2n + den over 2*den rounds half up
                if (!s1_reg[7])
                begin
                    num = $signed(43'(d1_reg) * 43'd65025) - $signed(43'(kdm1_reg));
                    num = (num <<< 1) + 43'sd65025;
                    den2_next = DEN_W'(130050);
                end
                else if (d1_reg < 8'd64)
                begin
                    num = $signed(43'(d1_reg) * 43'd16581375) + kx;
                    num = (num <<< 1) + 43'sd16581375;
                    den2_next = DEN_W'(33162750);
                end
                else
                begin
                    num = $signed(43'(d1_reg) * 43'd16711680) + kx;
                    num = (num <<< 1) + 43'sd16711680;
                    den2_next = DEN_W'(33423360);
                end
                num2_next = num[42] ? '0 : num[NUM_W-1:0];
            end
            MODE_DIFFERENCE:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = mx - mn;
            end
            MODE_LINBURN:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = (sum >= 9'd255) ? 8'(sum - 9'd255) : 8'd0;
            end
            MODE_PINLIGHT:
            begin
                side2_next.post = POST_BYPASS;
                if (!s1_reg[7])
                begin
                    t = {s1_reg[6:0], 1'b0};
                    side2_next.byp = (d1_reg < t) ? d1_reg : t;
                end
                else
                begin
                    t = {s1_reg[6:0], 1'b0};
                    side2_next.byp = (d1_reg > t) ? d1_reg : t;
                end
            end
            MODE_EXCLUSION:
            begin
                num2_next = NUM_W'(sd1_reg) + NUM_W'(127);
                side2_next.post = POST_EXCL;
            end
            MODE_LINDODGE:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = sum[8] ? 8'd255 : sum[7:0];
            end
            MODE_SUBTRACT:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = (d1_reg > s1_reg) ? d1_reg - s1_reg : 8'd0;
            end
            MODE_DIVIDE:
            begin
                if (s1_reg == 8'd0)
                begin
                    side2_next.post = POST_BYPASS;
                    side2_next.byp  = 8'd255;
                end
                else
                begin
                    num2_next = NUM_W'(d1_reg) * NUM_W'(255) + NUM_W'(s1_reg >> 1);
                    den2_next = DEN_W'(s1_reg);
                end
            end
            default:
            begin
                side2_next.post = POST_BYPASS;
                side2_next.byp  = s1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            num2_reg  <= num2_next;
            den2_reg  <= den2_next;
            side2_reg <= side2_next;
        end
    end

    sbl_div u_div (
        .clk      (clk),
        .load     (ctl.load[DIV_STAGES+2:3]),
        .num      (num2_reg),
        .den      (den2_reg),
        .side_in  (side2_reg),
        .quot     (quot),
        .side_out (side_q)
    );

    always_comb
    begin
        logic signed [10:0] ex;
        ex = $signed({2'b0, side_q.sum}) - $signed({2'b0, quot, 1'b0});
        case (side_q.post)
            POST_QUOT:   res_next = quot;
            POST_INV:    res_next = 8'd255 - quot;
            POST_EXCL:   res_next = ex[10] ? 8'd0 : ((ex > 11'sd255) ? 8'd255 : ex[7:0]);
            POST_BYPASS: res_next = side_q.byp;
            default:     res_next = side_q.byp;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[NUM_STAGES-1])
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

### rtl/separable_pixel_blend.sv
// ----------------------------------------------------------------------------
// separable_pixel_blend
// Per-channel RGB blend of a source over a destination pixel, 17 modes.
// ----------------------------------------------------------------------------
// Usage:
//   Send one source/destination pixel pair per item on the s_axis channel;
//   the blended RGB pixel leaves on the m_axis channel in the same order.
//   The blend mode is written through cfg_we/cfg_wdata while no item is in
//   flight; codes 17..31 pass the source channel through.
// Pipeline: 8 register stages (3 product/select stages, 4 divider stages at
//   two quotient bits each, 1 finish register); an accepted item passes
//   through them in order and is then offered on m_axis.
// Throughput: one item per cycle while m_axis_tready does not stall; every
//   stage of the three channel lanes is fully pipelined and hands on its item.
// Stall: each stage loads when it is empty or its successor moves, so
//   bubbles collapse and the input keeps accepting until all 8 stages hold
//   items behind a stalled m_axis_tready.
// Reset: rst_n clears all valid bits and sets the mode to normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "separable_pixel_blend_defines.svh"

module separable_pixel_blend
    import sbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,      // blend_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_red, src_green, src_blue, dst_red, dst_green, dst_blue
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] m_axis_tdata
);

    logic [4:0]            blend_mode_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_rdy;
    sbl_ctl_t              ctl;
    logic [7:0]            lane_out [NUM_LANES];

    // Hold the mode; user writes only while the pipe is drained; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= MODE_NORMAL;
        end
        else if (cfg_we)
        begin
            blend_mode_reg <= cfg_wdata;
        end
    end

    // A stage is ready when empty or when its successor advances
    always_comb
    begin
        stage_rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (i == 0)
            begin
                ctl.load[i] = stage_rdy[i] && s_axis_tvalid;
            end
            else
            begin
                ctl.load[i] = stage_rdy[i] && valid_reg[i-1];
            end
            valid_next[i] = stage_rdy[i] ? ctl.load[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Channel lanes side by side; m_axis_tdata concatenates their finish registers
    genvar c;
    generate
        for (c = 0; c < NUM_LANES; c++)
        begin : g_lane
            sbl_lane u_lane (
                .clk    (clk),
                .ctl    (ctl),
                .mode   (blend_mode_reg),
                .src    (s_axis_tdata[8*c +: 8]),
                .dst    (s_axis_tdata[8*(c+NUM_LANES) +: 8]),
                .result (lane_out[c])
            );
        end
    endgenerate

    assign s_axis_tready = stage_rdy[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {lane_out[2], lane_out[1], lane_out[0]};

    `SBL_ASSERT_IMP(a_empty_head_ready, !valid_reg[0], s_axis_tready)
    `SBL_ASSERT_NXT(a_accept_fills_head, s_axis_tvalid && s_axis_tready, valid_reg[0])
    `SBL_ASSERT_NXT(a_drain_empties_out,
        m_axis_tvalid && m_axis_tready && !valid_reg[NUM_STAGES-2], !m_axis_tvalid)

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for separable_pixel_blend. An in-bench blend model
// predicts every pixel, and the checker compares each output pixel, channel
// by channel, in order. Directed corner pixels come first, then random
// pixels under random modes. The random part runs with several patterns of
// source gaps and sink stalls, plus one long sink hold-off.
// ----------------------------------------------------------------------------

module tb_top;
    import sbl_pkg::*;

    localparam int PIPE_LAT  = 8;
    localparam int RUN_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    logic [23:0] pixel_q [$];   // predicted blended pixels, oldest first
    logic [4:0]  cur_mode;
    int          src_gap_pct;
    int          sink_stall_pct;
    int          hold_cycles;
    int          cycle_cnt;
    int          err_cnt;

    separable_pixel_blend dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Blend model
    // ------------------------------------------------------------------
    function automatic logic [7:0] clamp8(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Q1.16 sqrt(d/255), rounded; floor root found by bitwise search.
    function automatic longint sqrt_q16(longint d);
        longint n;
        longint r;
        n = (d << 34) / 255;
        r = 0;
        for (int b = 17; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        end
        return (r + 1) >>> 1;
    endfunction

    function automatic logic [7:0] round_q(longint num, longint den);
        if (num < 0)
            return 8'd0;
        return clamp8((2 * num + den) / (2 * den));
    endfunction

    function automatic logic [7:0] soft_light_ch(longint s, longint d);
        longint k;
        longint p;
        if (s <= 127)
        begin
            k = 255 - 2 * s;
            return round_q(65025 * d - k * d * (255 - d), 65025);
        end
        k = 2 * s - 255;
        if (d <= 63)
        begin
            p = ((16 * d - 3060) * d + 260100) * d;
            return round_q(16581375 * d + k * (p - 65025 * d), 16581375);
        end
        return round_q(16711680 * d + k * (255 * sqrt_q16(d) - 65536 * d), 16711680);
    endfunction

    function automatic logic [7:0] blend_ch(logic [7:0] su, logic [7:0] du, logic [4:0] mode);
        longint s;
        longint d;
        s = su;
        d = du;
        case (mode)
            MODE_MULTIPLY:   return clamp8(s * d / 255);
            MODE_SCREEN:     return clamp8(255 - (255 - s) * (255 - d) / 255);
            MODE_OVERLAY:    return (d < 128) ? clamp8(2 * s * d / 255)
                                              : clamp8(255 - 2 * (255 - s) * (255 - d) / 255);
            MODE_DARKEN:     return (s < d) ? su : du;
            MODE_LIGHTEN:    return (s > d) ? su : du;
            MODE_DODGE:      return (s == 255) ? 8'd255 : clamp8(d * 255 / (255 - s));
            MODE_BURN:       return (s == 0) ? 8'd0
                                             : clamp8(255 - longint'(clamp8((255 - d) * 255 / s)));
            MODE_HARDLIGHT:  return (s < 128) ? clamp8(2 * s * d / 255)
                                              : clamp8(255 - 2 * (255 - s) * (255 - d) / 255);
            MODE_SOFTLIGHT:  return soft_light_ch(s, d);
            MODE_DIFFERENCE: return (d > s) ? 8'(d - s) : 8'(s - d);
            MODE_LINBURN:    return clamp8(s + d - 255);
            MODE_PINLIGHT:   return (s < 128) ? ((d < 2 * s) ? du : 8'(2 * s))
                                              : ((d > 2 * (s - 128)) ? du : 8'(2 * (s - 128)));
            MODE_EXCLUSION:  return clamp8(s + d - 2 * ((s * d + 127) / 255));
            MODE_LINDODGE:   return clamp8(s + d);
            MODE_SUBTRACT:   return clamp8(d - s);
            MODE_DIVIDE:     return (s == 0) ? 8'd255 : clamp8((d * 255 + s / 2) / s);
            default:         return su;
        endcase
    endfunction

    function automatic logic [23:0] blend_pixel(logic [47:0] item, logic [4:0] mode);
        logic [23:0] px;
        for (int c = 0; c < 3; c++)
            px[c*8 +: 8] = blend_ch(item[c*8 +: 8], item[(c+3)*8 +: 8], mode);
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stalls, plus a hold-off counted down here
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check each output item against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("%0t: unexpected pixel %h", $time, m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (m_axis_tdata[c*8 +: 8] !== pixel_q[0][c*8 +: 8])
                    begin
                        $display("%0t: channel %0d expected %h actual %h", $time, c,
                                 pixel_q[0][c*8 +: 8], m_axis_tdata[c*8 +: 8]);
                        err_cnt++;
                    end
                end
                void'(pixel_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT)
        begin
            $display("separable_pixel_blend verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    // Offer one item, idle first at the current gap rate; hold valid
    // until accepted, then record the prediction.
    task automatic send_pixel(logic [47:0] item);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixel_q.push_back(blend_pixel(item, cur_mode));
    endtask

    // Drain the pipe, then write the mode register.
    task automatic set_mode(logic [4:0] mode);
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_mode = mode;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] edges [8] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(3) == 0)
            return edges[$urandom_range(7)];
        return 8'($urandom);
    endfunction

    function automatic logic [47:0] rand_pixel();
        logic [47:0] item;
        for (int c = 0; c < 6; c++)
            item[c*8 +: 8] = pick_byte();
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // One corner pixel for each code 0..17: red s=0/d=255, green s=255/d=0,
    // blue s=128/d=64; mode 31 stands for the undefined codes, with s=0/d=255 on all channels.
    task automatic test_modes_directed();
        for (int m = 0; m <= 17; m++)
        begin
            set_mode(5'(m));
            send_pixel({8'd64, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0});
        end
        set_mode(5'd31);
        send_pixel({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    endtask

    // Soft light around its branch points: s 127/128, d 63/64, both ends.
    task automatic test_soft_light_edges();
        set_mode(MODE_SOFTLIGHT);
        send_pixel({8'd63, 8'd64, 8'd0, 8'd127, 8'd128, 8'd255});
        send_pixel({8'd64, 8'd63, 8'd255, 8'd128, 8'd127, 8'd0});
        send_pixel({8'd255, 8'd1, 8'd254, 8'd255, 8'd0, 8'd1});
    endtask

    // Random pixels in chunks, each chunk under a fresh mode.
    task automatic test_random(int n, int gap_pct, int stall_pct);
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
                set_mode(5'($urandom_range(31) < 24 ? $urandom_range(16) : $urandom_range(31)));
            send_pixel(rand_pixel());
        end
    endtask

    // Hold the sink off while the source keeps offering, to fill the pipe.
    task automatic test_backpressure();
        set_mode(MODE_SOFTLIGHT);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_cycles    = 300;
        for (int i = 0; i < 40; i++)
            send_pixel(rand_pixel());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 5'd0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 48'd0;
        m_axis_tready  = 1'b0;
        cur_mode       = MODE_NORMAL;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_cycles    = 0;
        cycle_cnt      = 0;
        err_cnt        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mode is normal; check it before any write.
        send_pixel({8'd1, 8'd2, 8'd3, 8'd255, 8'd128, 8'd0});
        test_modes_directed();
        test_soft_light_edges();
        test_random(360, 0, 0);
        test_random(360, 70, 0);
        test_random(360, 0, 70);
        test_random(360, 7, 7);
        test_backpressure();
        set_mode(MODE_DIVIDE);

        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        if (err_cnt == 0)
            $display("separable_pixel_blend verification clean");
        else
            $display("separable_pixel_blend verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sbl_pkg.sv
rtl/sbl_div.sv
rtl/sbl_lane.sv
rtl/separable_pixel_blend.sv
sim/tb_top.sv
